@@ sv/swp_pkg.sv @@
`default_nettype none

package swp_pkg;

   // Default depth of the sample window.
   localparam int WINDOW_DEFAULT = 300;

   // Field and register widths.
   localparam int SAMPLE_W    = 16;
   localparam int FILL_W      = 9;
   localparam int INTERVAL_W  = 8;
   localparam int PCT_W       = 7;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   // Register indexes on the write port.
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERVAL = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PCT      = 4'd1;

   // Register values after reset.
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd10;
   localparam logic [PCT_W-1:0]      PCT_RESET      = 7'd95;

   // Rank arithmetic: k = (pct * (n - 1) + 50) / 100, with the division done
   // as a multiplication by 2^24 / 100 followed by one correction step.
   localparam logic [6:0]  RANK_ROUND   = 7'd50;
   localparam logic [6:0]  RANK_SCALE   = 7'd100;
   localparam int          RECIP_W      = 18;
   localparam int          RECIP_SHIFT  = 24;
   localparam logic [17:0] RECIP_MULT   = 18'd167772;
   localparam int          RANK_LATENCY = 4;

   typedef logic [SAMPLE_W-1:0] sample_type;

   // What one cell of the sorted chain shows its neighbors.
   typedef struct packed {
      sample_type value;
      logic       valid;
      logic       le_new;
      logic       lt_evict;
   } cell_link_type;

endpackage

`default_nettype wire

@@ sv/swp_ram.sv @@
`default_nettype none

module swp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 300,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/swp_cell.sv @@
`default_nettype none

module swp_cell #(
   parameter int INDEX_W    = 9,
   parameter int CELL_INDEX = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic                  shift,
   input  wire logic                  full,
   input  wire logic                  evict_low,
   input  wire swp_pkg::sample_type   new_sample,
   input  wire swp_pkg::sample_type   evict_value,
   input  wire logic [INDEX_W-1:0]    rank,
   input  wire swp_pkg::cell_link_type left,
   input  wire swp_pkg::cell_link_type right,
   input  wire swp_pkg::sample_type   pass_prev,
   output swp_pkg::cell_link_type     link,
   output swp_pkg::sample_type        pass_out
);

   import swp_pkg::*;

   sample_type value_ff;
   sample_type value_in;
   logic       valid_ff;
   logic       valid_in;
   sample_type pass_ff;
   sample_type pass_in;

   // Compare the held value against the incoming and the outgoing sample.
   always_comb begin
      link.value    = value_ff;
      link.valid    = valid_ff;
      link.le_new   = valid_ff & (value_ff <= new_sample);
      link.lt_evict = full ? (valid_ff & (value_ff < evict_value)) : valid_ff;
   end

   // Next content of the cell. When the evicted value lies at or below the new
   // sample, the cells between the two close up toward the low end; otherwise
   // they move up by one toward the evicted entry or the end of the fill.
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (evict_low) begin
         priority if (link.lt_evict) begin
            value_in = value_ff;
         end else if (right.le_new) begin
            value_in = right.value;
            valid_in = right.valid;
         end else if (link.le_new) begin
            value_in = new_sample;
            valid_in = 1'b1;
         end else begin
            value_in = value_ff;
         end
      end else begin
         priority if (link.le_new) begin
            value_in = value_ff;
         end else if (left.le_new) begin
            value_in = new_sample;
            valid_in = 1'b1;
         end else if (left.lt_evict) begin
            value_in = left.value;
            valid_in = left.valid;
         end else begin
            value_in = value_ff;
         end
      end
   end

   // The readout bus picks up this cell's value when its place is the rank.
   assign pass_in = (rank == INDEX_W'(CELL_INDEX)) ? value_ff : pass_prev;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (step) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         value_ff <= value_in;
      end
      if (shift) begin
         pass_ff <= pass_in;
      end
   end

   assign pass_out = pass_ff;

endmodule

`default_nettype wire

@@ sv/swp_rank.sv @@
`default_nettype none

module swp_rank #(
   parameter int CNT_W   = 9,
   parameter int INDEX_W = 9
) (
   input  wire logic                      clock,
   input  wire logic [swp_pkg::PCT_W-1:0] pct,
   input  wire logic [CNT_W-1:0]          last_index,
   output logic [INDEX_W-1:0]             rank
);

   import swp_pkg::*;

   localparam int PROD_W = PCT_W + CNT_W + 1;
   localparam int FULL_W = PROD_W + RECIP_W;
   localparam int Q_W    = PROD_W + RECIP_W - RECIP_SHIFT;

   logic [PROD_W-1:0]  prod_ff;
   logic [PROD_W-1:0]  prod_in;
   logic [PROD_W-1:0]  prod_hold_ff;
   logic [FULL_W-1:0]  recip_prod;
   logic [Q_W-1:0]     est_ff;
   logic [Q_W-1:0]     est_in;
   logic [PROD_W:0]    back;
   logic [PROD_W:0]    rem;
   logic [Q_W-1:0]     quot_ff;
   logic [Q_W-1:0]     quot_in;
   logic [PROD_W-1:0]  quot_ext;
   logic [PROD_W-1:0]  last_ext;
   logic [PROD_W-1:0]  clamp;
   logic [INDEX_W-1:0] rank_ff;

   // Scaled rank with rounding offset.
   assign prod_in = PROD_W'(pct) * PROD_W'(last_index) + PROD_W'(RANK_ROUND);

   // Quotient estimate by the reciprocal; it is exact or one short.
   assign recip_prod = FULL_W'(prod_ff) * FULL_W'(RECIP_MULT);
   assign est_in     = recip_prod[FULL_W-1 -: Q_W];

   // Correct the estimate with one compare of the remainder.
   assign back    = (PROD_W + 1)'(est_ff) * (PROD_W + 1)'(RANK_SCALE);
   assign rem     = {1'b0, prod_hold_ff} - back;
   assign quot_in = est_ff + Q_W'(rem >= (PROD_W + 1)'(RANK_SCALE));

   // A percent above 100 selects the largest held value.
   assign quot_ext = PROD_W'(quot_ff);
   assign last_ext = PROD_W'(last_index);
   assign clamp    = (quot_ext > last_ext) ? last_ext : quot_ext;

   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      prod_hold_ff <= prod_ff;
      est_ff       <= est_in;
      quot_ff      <= quot_in;
      rank_ff      <= clamp[INDEX_W-1:0];
   end

   assign rank = rank_ff;

endmodule

`default_nettype wire

@@ sv/sliding_window_percentile.sv @@
`default_nettype none

// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  req_sample
// rsp      out        rsp_valid / rsp_ready  rsp_percentile_value, rsp_window_fill
// csr      in         csr_write_en           csr_index, csr_data
//
// A transaction that yields no result does not hold the input; the next one can follow at once.
// A transaction that yields a result holds the input through the rank arithmetic, the
// readout bus crossing the cell chain and the result hand-off.
// Reset is synchronous and empties the chain; the sample RAM needs no clearing.
// A result waiting in the output register does not stop the input; only the next
// result stalls until the previous one is taken.

module sliding_window_percentile #(
   parameter int WINDOW = swp_pkg::WINDOW_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [swp_pkg::SAMPLE_W-1:0]    req_sample,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [swp_pkg::SAMPLE_W-1:0]         rsp_percentile_value,
   output logic [swp_pkg::FILL_W-1:0]           rsp_window_fill,
   input  wire logic                            csr_write_en,
   input  wire logic [swp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [swp_pkg::CSR_DATA_W-1:0]  csr_data
);

   import swp_pkg::*;

   localparam int CNT_W      = $clog2(WINDOW + 1);
   localparam int INDEX_W    = $clog2(WINDOW);
   localparam int RANK_CNT_W = $clog2(RANK_LATENCY);

   localparam cell_link_type LEFT_END  = '{value: '0, valid: 1'b1, le_new: 1'b1, lt_evict: 1'b0};
   localparam cell_link_type RIGHT_END = '{value: '0, valid: 1'b0, le_new: 1'b0, lt_evict: 1'b0};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RANK,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type               state_ff;
   state_type               state_in;
   logic [RANK_CNT_W-1:0]   wait_ff;
   logic [RANK_CNT_W-1:0]   wait_in;
   logic [INDEX_W-1:0]      scan_ff;
   logic [INDEX_W-1:0]      scan_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   sample_type              rsp_value_ff;
   sample_type              rsp_value_in;
   logic [FILL_W-1:0]       rsp_fill_ff;
   logic [FILL_W-1:0]       rsp_fill_in;

   logic [INTERVAL_W-1:0]   interval_ff;
   logic [PCT_W-1:0]        pct_ff;
   logic [CNT_W-1:0]        fill_ff;
   logic [CNT_W-1:0]        fill_in;
   logic [INDEX_W-1:0]      slot_ff;
   logic [INDEX_W-1:0]      slot_in;
   logic [INTERVAL_W-1:0]   since_ff;
   logic [INTERVAL_W-1:0]   since_in;
   logic [INTERVAL_W-1:0]   since_next;
   logic [CNT_W-1:0]        last_index_ff;
   logic [CNT_W-1:0]        last_index_in;

   logic                    accept;
   logic                    full;
   logic                    fire;
   logic                    evict_low;
   logic                    shift;
   sample_type              evict_value;
   logic [INDEX_W-1:0]      wr_addr;
   logic [INDEX_W-1:0]      rd_addr;
   logic [INDEX_W-1:0]      rank;

   cell_link_type           links  [WINDOW];
   sample_type              passes [WINDOW];
   logic [WINDOW-1:0]       valid_vec;
   logic [WINDOW-1:0]       order_ok;

   assign accept = req_valid & req_ready;
   assign full   = (fill_ff == CNT_W'(WINDOW));

   // Window bookkeeping: fill first, then overwrite the oldest entry.
   always_comb begin
      fill_in       = full ? fill_ff : fill_ff + 1'b1;
      slot_in       = slot_ff;
      if (full) begin
         slot_in = (slot_ff == INDEX_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
      end
      since_next    = since_ff + 1'b1;
      fire          = (since_next >= interval_ff);
      since_in      = fire ? '0 : since_next;
      last_index_in = full ? CNT_W'(WINDOW - 1) : fill_ff;
   end

   // The RAM keeps samples in arrival order so the value to evict is read ahead.
   assign wr_addr = full ? slot_ff : fill_ff[INDEX_W-1:0];
   assign rd_addr = accept ? slot_in : slot_ff;

   swp_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_addr),
      .wr_data (req_sample),
      .rd_addr (rd_addr),
      .rd_data (evict_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         slot_ff  <= '0;
         since_ff <= '0;
      end else if (accept) begin
         fill_ff  <= fill_in;
         slot_ff  <= slot_in;
         since_ff <= since_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         last_index_ff <= last_index_in;
      end
   end

   // Configuration registers; writes to other indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
         pct_ff      <= PCT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_INTERVAL: interval_ff <= csr_data[INTERVAL_W-1:0];
            CSR_PCT:      pct_ff      <= csr_data[PCT_W-1:0];
            default:      ;
         endcase
      end
   end

   swp_rank #(
      .CNT_W   (CNT_W),
      .INDEX_W (INDEX_W)
   ) u_rank (
      .clock      (clock),
      .pct        (pct_ff),
      .last_index (last_index_ff),
      .rank       (rank)
   );

   // Sorted chain of cells, lowest value at cell 0.
   assign evict_low = full & (evict_value <= req_sample);
   assign shift     = (state_ff == ST_SCAN);

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      cell_link_type left_link;
      cell_link_type right_link;
      sample_type    pass_prev;

      if (i == 0) begin : g_first
         assign left_link = LEFT_END;
         assign pass_prev = '0;
      end else begin : g_inner_left
         assign left_link = links[i-1];
         assign pass_prev = passes[i-1];
      end

      if (i == WINDOW - 1) begin : g_last
         assign right_link  = RIGHT_END;
         assign order_ok[i] = 1'b1;
      end else begin : g_inner_right
         assign right_link  = links[i+1];
         assign order_ok[i] = ~links[i+1].valid | (links[i].value <= links[i+1].value);
      end

      assign valid_vec[i] = links[i].valid;

      swp_cell #(
         .INDEX_W    (INDEX_W),
         .CELL_INDEX (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .step        (accept),
         .shift       (shift),
         .full        (full),
         .evict_low   (evict_low),
         .new_sample  (req_sample),
         .evict_value (evict_value),
         .rank        (rank),
         .left        (left_link),
         .right       (right_link),
         .pass_prev   (pass_prev),
         .link        (links[i]),
         .pass_out    (passes[i])
      );
   end

   // Sequencer: rank arithmetic, readout across the chain, then result hand-off.
   always_comb begin
      state_in     = state_ff;
      wait_in      = wait_ff;
      scan_in      = scan_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_fill_in  = rsp_fill_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && fire) begin
               state_in = ST_RANK;
               wait_in  = '0;
            end
         end
         ST_RANK: begin
            wait_in = wait_ff + 1'b1;
            if (wait_ff == RANK_CNT_W'(RANK_LATENCY - 1)) begin
               state_in = ST_SCAN;
               scan_in  = '0;
            end
         end
         ST_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (scan_ff == INDEX_W'(WINDOW - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = passes[WINDOW-1];
               rsp_fill_in  = FILL_W'(fill_ff);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wait_ff      <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_fill_ff  <= rsp_fill_in;
   end

   assign req_ready            = (state_ff == ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_percentile_value = rsp_value_ff;
   assign rsp_window_fill      = rsp_fill_ff;

   // The fill count never passes the window depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(WINDOW))
      else $error("fill count above window depth");

   // The chain holds exactly as many live cells as the fill count.
   a_chain_fill: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(fill_ff))
      else $error("cell chain occupancy differs from fill count");

   // The overwrite pointer only moves once the window is full.
   a_slot_full: assert property (@(posedge clock) disable iff (reset)
      (slot_ff != '0) |-> full)
      else $error("overwrite pointer moved before window filled");

   // Live cells stay in ascending order.
   a_sorted: assert property (@(posedge clock) disable iff (reset)
      &order_ok)
      else $error("cell chain out of order");

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import swp_pkg::*;

   localparam int WIN = WINDOW_DEFAULT;

   // One result transaction can hold the input for the rank arithmetic plus a
   // full pass over the cell chain, so every quiet period is sized from that.
   localparam int SETTLE_CYCLES = RANK_LATENCY + WIN + 16;
   localparam int STALL_LIMIT   = 8 * (RANK_LATENCY + WIN + 1);
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 192;

   // Register indexes that decode to nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_LO = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_HI = 4'hF;

   typedef struct packed {
      sample_type        value;
      logic [FILL_W-1:0] fill;
   } ptile_type;

   typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_type;

   typedef enum logic [1:0] {RDY_OPEN, RDY_COIN, RDY_HOLD, RDY_TOGGLE} ready_mode_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
      sample_type             sample;
      bit                     typed;
      sample_type             want_value;
      logic [FILL_W-1:0]      want_fill;
   } step_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [SAMPLE_W-1:0]    req_sample;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [SAMPLE_W-1:0]    rsp_percentile_value;
   logic [FILL_W-1:0]      rsp_window_fill;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // Shadow copy of the window and the registers.
   sample_type            win_store [WIN];
   int                    win_slot;
   int                    win_fill;
   logic [INTERVAL_W-1:0] win_since;
   logic [INTERVAL_W-1:0] win_interval;
   logic [PCT_W-1:0]      win_pct;

   ptile_type      pending_results[$];
   ptile_type      head_result;
   int             error_count = 0;
   int             idle_cycles = 0;
   bit             sent_since_idle = 1'b0;
   ready_mode_type ready_mode = RDY_OPEN;
   int             ready_left = 0;

   // Directed steps: extremes first, where the result is obvious, then the
   // register corner cases, which are left to the predictor.
   step_row_type directed_steps [22] = '{
      '{ROW_WRITE,  CSR_INTERVAL,  8'd1,   16'h0000, 1'b0, 16'h0000, 9'd0},
      '{ROW_WRITE,  CSR_PCT,       8'd0,   16'h0000, 1'b0, 16'h0000, 9'd0},
      '{ROW_SAMPLE, CSR_INTERVAL,  8'd0,   16'hFFFF, 1'b1, 16'hFFFF, 9'd1},
      '{ROW_SAMPLE, CSR_INTERVAL,  8'd0,   16'h0000, 1'b1, 16'h0000, 9'd2},
      '{ROW_WRITE,  CSR_PCT,       8'd100, 16'h0000, 1'b0, 16'h0000, 9'd0},
      '{ROW_SAMPLE, CSR_INTERVAL,  8'd0,   16'h1234, 1'b1, 16'hFFFF, 9'd3},
      '{ROW_WRITE,  CSR_PCT,       8'h7F,  16'h0000, 1'b0, 16'h0000, 9'd0},
      '{ROW_SAMPLE, CSR_INTERVAL,  8'd0,   16'h8000, 1'b1, 16'hFFFF, 9'd4},
      '{ROW_WRITE,  CSR_PCT,       8'hB2,  16'h0000, 1'b0, 16'h0000, 9'd0},
      '{ROW_SAMPLE, CSR_INTERVAL,  8'd0,   16'h5555, 1'b0, 16'h0000, 9'd0},
      '{ROW_WRITE,  CSR_UNUSED_LO, 8'h00,  16'h0000, 1'b0, 16'h0000, 9'd0},
      '{ROW_WRITE,  CSR_UNUSED_HI, 8'hFF,  16'h0000, 1'b0, 16'h0000, 9'd0},
      '{ROW_SAMPLE, CSR_INTERVAL,  8'd0,   16'h0001, 1'b0, 16'h0000, 9'd0},
      '{ROW_WRITE,  CSR_INTERVAL,  8'd0,   16'h0000, 1'b0, 16'h0000, 9'd0},
      '{ROW_SAMPLE, CSR_INTERVAL,  8'd0,   16'hAAAA, 1'b0, 16'h0000, 9'd0},
      '{ROW_SAMPLE, CSR_INTERVAL,  8'd0,   16'h0000, 1'b0, 16'h0000, 9'd0},
      '{ROW_WRITE,  CSR_INTERVAL,  8'd8,   16'h0000, 1'b0, 16'h0000, 9'd0},
      '{ROW_SAMPLE, CSR_INTERVAL,  8'd0,   16'h7FFF, 1'b0, 16'h0000, 9'd0},
      '{ROW_SAMPLE, CSR_INTERVAL,  8'd0,   16'h00FF, 1'b0, 16'h0000, 9'd0},
      '{ROW_SAMPLE, CSR_INTERVAL,  8'd0,   16'hFF00, 1'b0, 16'h0000, 9'd0},
      '{ROW_WRITE,  CSR_INTERVAL,  8'd2,   16'h0000, 1'b0, 16'h0000, 9'd0},
      '{ROW_SAMPLE, CSR_INTERVAL,  8'd0,   16'h0003, 1'b0, 16'h0000, 9'd0}
   };

   // Register settings for the random phases, extremes included.
   logic [CSR_DATA_W-1:0] phase_interval [PHASES] = '{
      8'd1, 8'd255, 8'd10, 8'd0, 8'd3, 8'd20, 8'd2, 8'd64
   };
   logic [CSR_DATA_W-1:0] phase_pct [PHASES] = '{
      8'd0, 8'd100, 8'd95, 8'd127, 8'd50, 8'd1, 8'd99, 8'd73
   };

   sliding_window_percentile #(
      .WINDOW(WIN)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_percentile_value(rsp_percentile_value),
      .rsp_window_fill(rsp_window_fill),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // The receiver switches between open, random, held-off and toggling stretches.
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 3));
         ready_left <= $urandom_range(1, 64);
      end else begin
         ready_left <= ready_left - 1;
      end
      case (ready_mode)
         RDY_OPEN: begin
            rsp_ready <= 1'b1;
         end
         RDY_COIN: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         RDY_HOLD: begin
            rsp_ready <= 1'b0;
         end
         default: begin
            rsp_ready <= ~rsp_ready;
         end
      endcase
   end

   // Every result transaction is matched against the oldest expected result.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: percentile_value %h, window_fill %0d",
                   rsp_percentile_value, rsp_window_fill);
            error_count++;
         end else begin
            head_result = pending_results.pop_front();
            if (rsp_percentile_value !== head_result.value) begin
               $error("percentile_value: expected %h, actual %h",
                      head_result.value, rsp_percentile_value);
               error_count++;
            end
            if (rsp_window_fill !== head_result.fill) begin
               $error("window_fill: expected %0d, actual %0d",
                      head_result.fill, rsp_window_fill);
               error_count++;
            end
         end
      end
   end

   // The run ends if no transaction of any kind moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // Drop valid, wait for every expected result, then let the chain run dry.
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      sent_since_idle = 1'b0;
   endtask

   // Register writes only happen with the block idle; the shadow copy is
   // updated at the edge where the write lands.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      if (sent_since_idle) settle_pipeline();
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= data;
      @(posedge clock);
      if (idx == CSR_INTERVAL) begin
         win_interval = data[INTERVAL_W-1:0];
      end else if (idx == CSR_PCT) begin
         win_pct = data[PCT_W-1:0];
      end
   endtask

   // Append one expected result behind the ones already waiting.
   function automatic void queue_result(input ptile_type r);
      pending_results.insert(pending_results.size(), r);
   endfunction

   // Offer one sample and, once the transaction is accepted, advance the
   // shadow window and queue the percentile it should produce.
   task automatic send_sample(input sample_type s, input bit typed,
                              input ptile_type typed_result);
      ptile_type  calc;
      sample_type ranked [WIN];
      sample_type v;
      int         n;
      int         k;
      int         j;
      req_valid    <= 1'b1;
      req_sample   <= s;
      csr_write_en <= 1'b0;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_since_idle = 1'b1;

      // Append while filling, then overwrite the oldest entry.
      if (win_fill < WIN) begin
         win_store[win_fill] = s;
         win_fill++;
      end else begin
         win_store[win_slot] = s;
         win_slot = (win_slot + 1) % WIN;
      end

      win_since = win_since + 1'b1;
      if (win_since >= win_interval) begin
         win_since = '0;
         n = win_fill;
         k = (int'(win_pct) * (n - 1) + int'(RANK_ROUND)) / int'(RANK_SCALE);
         if (k > n - 1) k = n - 1;
         for (int i = 0; i < n; i++) begin
            v = win_store[i];
            j = i;
            while (j > 0 && ranked[j - 1] > v) begin
               ranked[j] = ranked[j - 1];
               j--;
            end
            ranked[j] = v;
         end
         calc.value = ranked[k];
         calc.fill  = n[FILL_W-1:0];
         if (!typed) queue_result(calc);
      end
      if (typed) queue_result(typed_result);
   endtask

   initial begin
      int                    gap;
      int                    burst_left;
      sample_type            s;
      logic [CSR_DATA_W-1:0] pct_data;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_sample   <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= CSR_INTERVAL;
      csr_data     <= '0;
      win_slot     = 0;
      win_fill     = 0;
      win_since    = '0;
      win_interval = INTERVAL_RESET;
      win_pct      = PCT_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      foreach (directed_steps[r]) begin
         if (directed_steps[r].kind == ROW_WRITE) begin
            write_reg(directed_steps[r].index, directed_steps[r].data);
         end else begin
            send_sample(directed_steps[r].sample, directed_steps[r].typed,
                        '{directed_steps[r].want_value, directed_steps[r].want_fill});
         end
      end

      // Random phases, each under its own register setting.
      for (int p = 0; p < PHASES; p++) begin
         pct_data    = phase_pct[p];
         pct_data[7] = 1'($urandom_range(0, 1));
         write_reg(CSR_INTERVAL, phase_interval[p]);
         write_reg(CSR_PCT, pct_data);
         write_reg(($urandom_range(0, 1) != 0) ? CSR_UNUSED_LO : CSR_UNUSED_HI,
                   8'($urandom));
         burst_left = 0;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Bursts of random length; a zero gap merges two bursts.
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               if (gap > 0) begin
                  req_valid    <= 1'b0;
                  csr_write_en <= 1'b0;
                  repeat (gap) @(posedge clock);
                  if ($urandom_range(0, 30) == 0) begin
                     while (pending_results.size() != 0) @(posedge clock);
                  end
               end
            end
            // Extremes and a narrow range for ties, the rest full range.
            case ($urandom_range(0, 7))
               0: s = '0;
               1: s = '1;
               2, 3: s = sample_type'($urandom_range(0, 15));
               default: s = sample_type'($urandom);
            endcase
            send_sample(s, 1'b0, '0);
            burst_left--;
         end
      end

      settle_pipeline();
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
